// ===== hdl/mfp_pkg.sv =====
// Shared types and constants for the motor fault protection block.
`default_nettype none
package mfp_pkg;

   localparam int TIMER_W = 17;
   localparam int ABS_W   = 17;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 16;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_RUN  = 2'd1,
      MODE_COOL = 2'd2
   } mode_type;

   localparam logic OP_UPDATE = 1'b0;
   localparam logic OP_CLEAR  = 1'b1;

   localparam logic [2:0] FLAG_OC = 3'b001;
   localparam logic [2:0] FLAG_OT = 3'b010;
   localparam logic [2:0] FLAG_ST = 3'b100;

   localparam logic [CSR_IDX_W-1:0] CSR_OC_LIMIT    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OT_LIMIT    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_STALL_SPEED = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_STALL_CUR   = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_STALL_TIME  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_COOL_TIME   = 3'd5;

   localparam logic [14:0]        RST_OC_LIMIT    = 15'd5000;
   localparam logic signed [15:0] RST_OT_LIMIT    = 16'sd800;
   localparam logic [14:0]        RST_STALL_SPEED = 15'd50;
   localparam logic [14:0]        RST_STALL_CUR   = 15'd3000;
   localparam logic [15:0]        RST_STALL_TIME  = 16'd500;
   localparam logic [15:0]        RST_COOL_TIME   = 16'd3000;

   typedef struct packed {
      logic [14:0]        overcurrent_limit;
      logic signed [15:0] overtemp_limit;
      logic [14:0]        stall_speed_limit;
      logic [14:0]        stall_current_limit;
      logic [15:0]        stall_time;
      logic [15:0]        cooldown_time;
   } cfg_type;

   typedef struct packed {
      logic               opcode;
      logic signed [15:0] current_ma;
      logic signed [15:0] temp_decic;
      logic signed [15:0] motor_speed;
   } req_type;

   typedef struct packed {
      logic [1:0]  mode;
      logic [2:0]  fault_bits;
      logic [15:0] faults_seen;
      logic        drive_enable;
   } rsp_type;

   // 17-bit magnitude of a 16-bit signed value; -32768 maps to 32768
   function automatic logic [ABS_W-1:0] abs17(input logic signed [15:0] v);
      logic [ABS_W-1:0] ext;
      begin
         ext = {v[15], v};
         abs17 = v[15] ? (~ext + 17'd1) : ext;
      end
   endfunction

endpackage
`default_nettype wire

// ===== hdl/mfp_if.sv =====
// Request and response channel interfaces.
`default_nettype none
interface mfp_req_if;
   logic               valid;
   logic               ready;
   logic               opcode;
   logic signed [15:0] current_ma;
   logic signed [15:0] temp_decic;
   logic signed [15:0] motor_speed;

   modport source(output valid, output opcode, output current_ma, output temp_decic,
                  output motor_speed, input ready);
   modport sink(input valid, input opcode, input current_ma, input temp_decic,
                input motor_speed, output ready);
endinterface

interface mfp_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  mode;
   logic [2:0]  fault_bits;
   logic [15:0] faults_seen;
   logic        drive_enable;

   modport source(output valid, output mode, output fault_bits, output faults_seen,
                  output drive_enable, input ready);
   modport sink(input valid, input mode, input fault_bits, input faults_seen,
                input drive_enable, output ready);
endinterface
`default_nettype wire

// ===== hdl/motor_fault_protection_top.sv =====
// Top level of the motor overcurrent, overtemperature and stall protection block.
//
// Each request beat is either an update sample (one tick of TICK_MS ms) carrying
// signed current, temperature and speed, or a clear command. Every request beat
// yields exactly one response beat: mode, fault flags, fault count, drive enable.
// Limits and times are set through the csr_ port, one register per write; write
// them only while no request is in flight.
// A request is captured in the input register, updated by the compare and timer logic,
// and the result is captured in the result register, which drives the rsp channel.
// Throughput: one beat per cycle while rsp.ready stays high, set by the combinational
// compare and timer update feeding the state registers.
// Reset (synchronous, active high) restores the default limits, sets the mode to
// idle, clears flags, timers and the fault count, and drops rsp.valid.
// When the receiver stalls, the result register holds its beat and the input
// register still takes one more request; after that req.ready falls until
// rsp.ready returns.
`default_nettype none
module motor_fault_protection_top #(
   parameter int TICK_MS = 10
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   mfp_req_if.sink                             req,
   mfp_rsp_if.source                           rsp,
   input  wire logic                           csr_we,
   input  wire logic [mfp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mfp_pkg::CSR_DATA_W-1:0] csr_wdata
);

   mfp_pkg::cfg_type cfg;
   mfp_pkg::req_type req_data;
   mfp_pkg::rsp_type res_data;
   mfp_pkg::rsp_type out_data;
   logic             res_valid, res_ready;
   logic             req_ready;
   logic             out_valid;

   assign req_data.opcode      = req.opcode;
   assign req_data.current_ma  = req.current_ma;
   assign req_data.temp_decic  = req.temp_decic;
   assign req_data.motor_speed = req.motor_speed;
   assign req.ready            = req_ready;

   mfp_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   mfp_engine #(
      .TICK_MS (TICK_MS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .in_valid  (req.valid),
      .in_ready  (req_ready),
      .in_data   (req_data),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res_data  (res_data)
   );

   mfp_out_reg u_out_reg (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (res_valid),
      .in_ready  (res_ready),
      .in_data   (res_data),
      .out_valid (out_valid),
      .out_ready (rsp.ready),
      .out_data  (out_data)
   );

   assign rsp.valid        = out_valid;
   assign rsp.mode         = out_data.mode;
   assign rsp.fault_bits   = out_data.fault_bits;
   assign rsp.faults_seen  = out_data.faults_seen;
   assign rsp.drive_enable = out_data.drive_enable;

endmodule
`default_nettype wire

// ===== hdl/mfp_csr.sv =====
// Configuration register file.
`default_nettype none
module mfp_csr (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_we,
   input  wire logic [mfp_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [mfp_pkg::CSR_DATA_W-1:0]     csr_wdata,
   output mfp_pkg::cfg_type                        cfg
);

   mfp_pkg::cfg_type cfg_ff;
   mfp_pkg::cfg_type cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            mfp_pkg::CSR_OC_LIMIT:    cfg_in.overcurrent_limit   = csr_wdata[14:0];
            mfp_pkg::CSR_OT_LIMIT:    cfg_in.overtemp_limit      = $signed(csr_wdata);
            mfp_pkg::CSR_STALL_SPEED: cfg_in.stall_speed_limit   = csr_wdata[14:0];
            mfp_pkg::CSR_STALL_CUR:   cfg_in.stall_current_limit = csr_wdata[14:0];
            mfp_pkg::CSR_STALL_TIME:  cfg_in.stall_time          = csr_wdata;
            mfp_pkg::CSR_COOL_TIME:   cfg_in.cooldown_time       = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.overcurrent_limit   <= mfp_pkg::RST_OC_LIMIT;
         cfg_ff.overtemp_limit      <= mfp_pkg::RST_OT_LIMIT;
         cfg_ff.stall_speed_limit   <= mfp_pkg::RST_STALL_SPEED;
         cfg_ff.stall_current_limit <= mfp_pkg::RST_STALL_CUR;
         cfg_ff.stall_time          <= mfp_pkg::RST_STALL_TIME;
         cfg_ff.cooldown_time       <= mfp_pkg::RST_COOL_TIME;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

// ===== hdl/mfp_engine.sv =====
// Input register, protection state and per-beat update logic.
`default_nettype none
module mfp_engine #(
   parameter int TICK_MS = 10
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire mfp_pkg::cfg_type  cfg,
   input  wire logic              in_valid,
   output logic                   in_ready,
   input  wire mfp_pkg::req_type  in_data,
   output logic                   res_valid,
   input  wire logic              res_ready,
   output mfp_pkg::rsp_type       res_data
);

   localparam int TimerW = mfp_pkg::TIMER_W;
   localparam logic [TimerW-1:0] Tick = TimerW'(TICK_MS);

   logic                  s1_valid_ff, s1_valid_in;
   mfp_pkg::req_type      s1_data_ff;
   logic                  advance;

   mfp_pkg::mode_type     mode_ff, mode_in;
   logic [2:0]            fault_ff, fault_in;
   logic [TimerW-1:0]     stall_ff, stall_in;
   logic [TimerW-1:0]     cool_ff, cool_in;
   logic [15:0]           total_ff, total_in;

   logic [mfp_pkg::ABS_W-1:0] acur, aspd;
   logic [TimerW-1:0]     stall_sum, cool_sum;
   logic                  oc_hit, ot_hit, stall_cond;

   assign advance     = s1_valid_ff && res_ready;
   assign in_ready    = !s1_valid_ff || res_ready;
   assign s1_valid_in = (in_valid && in_ready) ? 1'b1 : (advance ? 1'b0 : s1_valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         s1_data_ff <= in_data;
      end
   end

   assign acur       = mfp_pkg::abs17(s1_data_ff.current_ma);
   assign aspd       = mfp_pkg::abs17(s1_data_ff.motor_speed);
   assign oc_hit     = acur > {2'b00, cfg.overcurrent_limit};
   assign ot_hit     = $signed(s1_data_ff.temp_decic) > $signed(cfg.overtemp_limit);
   assign stall_cond = (aspd < {2'b00, cfg.stall_speed_limit}) &&
                       (acur > {2'b00, cfg.stall_current_limit});
   assign stall_sum  = stall_ff + Tick;
   assign cool_sum   = cool_ff + Tick;

   // next state
   always_comb begin
      mode_in  = mode_ff;
      fault_in = fault_ff;
      stall_in = stall_ff;
      cool_in  = cool_ff;
      total_in = total_ff;
      if (advance) begin
         priority if (s1_data_ff.opcode == mfp_pkg::OP_CLEAR) begin
            fault_in = 3'b000;
            stall_in = '0;
            cool_in  = '0;
            mode_in  = mfp_pkg::MODE_IDLE;
         end else if (mode_ff == mfp_pkg::MODE_COOL) begin
            if (cool_sum >= {1'b0, cfg.cooldown_time}) begin
               cool_in  = '0;
               fault_in = 3'b000;
               mode_in  = mfp_pkg::MODE_IDLE;
            end else begin
               cool_in = cool_sum;
            end
         end else if (oc_hit) begin
            fault_in = fault_ff | mfp_pkg::FLAG_OC;
            total_in = total_ff + 16'd1;
            cool_in  = '0;
            mode_in  = mfp_pkg::MODE_COOL;
         end else if (ot_hit) begin
            fault_in = fault_ff | mfp_pkg::FLAG_OT;
            total_in = total_ff + 16'd1;
            cool_in  = '0;
            mode_in  = mfp_pkg::MODE_COOL;
         end else if (stall_cond) begin
            if (stall_sum >= {1'b0, cfg.stall_time}) begin
               stall_in = '0;
               fault_in = fault_ff | mfp_pkg::FLAG_ST;
               total_in = total_ff + 16'd1;
               cool_in  = '0;
               mode_in  = mfp_pkg::MODE_COOL;
            end else begin
               stall_in = stall_sum;
               mode_in  = mfp_pkg::MODE_RUN;
            end
         end else begin
            stall_in = '0;
            mode_in  = mfp_pkg::MODE_RUN;
         end
      end
   end

   // result beat from the updated state
   always_comb begin
      res_data.mode        = mode_in;
      res_data.fault_bits  = fault_in;
      res_data.faults_seen = total_in;
      unique case (mode_in)
         mfp_pkg::MODE_IDLE,
         mfp_pkg::MODE_RUN: res_data.drive_enable = 1'b1;
         default:           res_data.drive_enable = 1'b0;
      endcase
   end

   assign res_valid = s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= mfp_pkg::MODE_IDLE;
         fault_ff <= 3'b000;
         stall_ff <= '0;
         cool_ff  <= '0;
         total_ff <= 16'd0;
      end else begin
         mode_ff  <= mode_in;
         fault_ff <= fault_in;
         stall_ff <= stall_in;
         cool_ff  <= cool_in;
         total_ff <= total_in;
      end
   end

endmodule
`default_nettype wire

// ===== hdl/mfp_out_reg.sv =====
// Result register between the update logic and the response channel.
`default_nettype none
module mfp_out_reg (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             in_valid,
   output logic                  in_ready,
   input  wire mfp_pkg::rsp_type in_data,
   output logic                  out_valid,
   input  wire logic             out_ready,
   output mfp_pkg::rsp_type      out_data
);

   logic             valid_ff, valid_in;
   mfp_pkg::rsp_type data_ff;

   assign in_ready = !valid_ff || out_ready;
   assign valid_in = (in_valid && in_ready) ? 1'b1 : (out_ready ? 1'b0 : valid_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         data_ff <= in_data;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule
`default_nettype wire

// ===== hdl/mfp_checker.sv =====
// Port-level assertions for the protection block, bound to the top level.
`default_nettype none
module mfp_port_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_mode,
   input wire logic [2:0]  rsp_fault_bits,
   input wire logic [15:0] rsp_faults_seen,
   input wire logic        rsp_drive_enable
);

   // drive is cut exactly in cooldown
   a_drive_vs_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_drive_enable == (rsp_mode != mfp_pkg::MODE_COOL)))
      else $error("drive_enable disagrees with mode");

   // a flag is set exactly while cooling down, and only one at a time
   a_flags_vs_mode: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ($onehot0(rsp_fault_bits) &&
                     ((rsp_fault_bits != 3'b000) == (rsp_mode == mfp_pkg::MODE_COOL))))
      else $error("fault flags inconsistent with mode");

   a_no_beat_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("response beat right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_mode) &&
         $stable(rsp_fault_bits) && $stable(rsp_faults_seen) && $stable(rsp_drive_enable)))
      else $error("stalled response beat changed");

endmodule

bind motor_fault_protection_top mfp_port_checker u_mfp_checker (
   .clock            (clock),
   .reset            (reset),
   .rsp_valid        (rsp.valid),
   .rsp_ready        (rsp.ready),
   .rsp_mode         (rsp.mode),
   .rsp_fault_bits   (rsp.fault_bits),
   .rsp_faults_seen  (rsp.faults_seen),
   .rsp_drive_enable (rsp.drive_enable)
);
`default_nettype wire

// ===== dv/mfp_checker.sv =====
// Checker for the motor fault protection block: predicts every response beat and compares it.
module mfp_checker #(
   parameter int TICK_MS = 10
) (
   input  wire logic                           clock,
   input  wire logic                           reset,
   mfp_req_if                                  req,
   mfp_rsp_if                                  rsp,
   input  wire logic                           csr_we,
   input  wire logic [mfp_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [mfp_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                                  mismatches,
   output int                                  outstanding,
   output int                                  checked
);

   logic [14:0]        oc_lim;
   logic signed [15:0] ot_lim;
   logic [14:0]        stall_spd_lim;
   logic [14:0]        stall_cur_lim;
   logic [15:0]        stall_ms;
   logic [15:0]        cool_ms;

   mfp_pkg::mode_type  mode_q;
   logic [2:0]         flags_q;
   logic [16:0]        stall_tmr;
   logic [16:0]        cool_tmr;
   logic [15:0]        fault_cnt;

   mfp_pkg::rsp_type   rsp_due[$];
   int                 err_cnt = 0;
   int                 seen_cnt = 0;

   function automatic logic [16:0] magnitude(input logic signed [15:0] v);
      int w;
      w = v;
      if (w < 0) w = -w;
      return w[16:0];
   endfunction

   function automatic void enter_cooldown(input logic [2:0] flag);
      flags_q   = flags_q | flag;
      fault_cnt = fault_cnt + 16'd1;
      cool_tmr  = '0;
      mode_q    = mfp_pkg::MODE_COOL;
   endfunction

   function automatic mfp_pkg::rsp_type protect_step(input logic op,
                                            input logic signed [15:0] cur, temp, spd);
      logic [16:0]      acur;
      logic [16:0]      aspd;
      mfp_pkg::rsp_type r;
      acur = magnitude(cur);
      aspd = magnitude(spd);
      if (op == mfp_pkg::OP_CLEAR) begin
         flags_q   = '0;
         stall_tmr = '0;
         cool_tmr  = '0;
         mode_q    = mfp_pkg::MODE_IDLE;
      end else if (mode_q == mfp_pkg::MODE_COOL) begin
         // stall timer is left alone while cooling down
         cool_tmr = cool_tmr + 17'(TICK_MS);
         if (cool_tmr >= cool_ms) begin
            cool_tmr = '0;
            flags_q  = '0;
            mode_q   = mfp_pkg::MODE_IDLE;
         end
      end else if (acur > oc_lim) begin
         enter_cooldown(mfp_pkg::FLAG_OC);
      end else if (temp > ot_lim) begin
         enter_cooldown(mfp_pkg::FLAG_OT);
      end else if (aspd < stall_spd_lim && acur > stall_cur_lim) begin
         stall_tmr = stall_tmr + 17'(TICK_MS);
         if (stall_tmr >= stall_ms) begin
            stall_tmr = '0;
            enter_cooldown(mfp_pkg::FLAG_ST);
         end else begin
            mode_q = mfp_pkg::MODE_RUN;
         end
      end else begin
         stall_tmr = '0;
         mode_q    = mfp_pkg::MODE_RUN;
      end
      r.mode         = mode_q;
      r.fault_bits   = flags_q;
      r.faults_seen  = fault_cnt;
      r.drive_enable = (mode_q == mfp_pkg::MODE_IDLE || mode_q == mfp_pkg::MODE_RUN);
      return r;
   endfunction

   function automatic void field_err(input string name, input logic [15:0] want,
                                     input logic [15:0] got);
      $display("%0t checker: %s expected %0d got %0d", $time, name, want, got);
      err_cnt++;
   endfunction

   always @(posedge clock) begin
      mfp_pkg::rsp_type got;
      mfp_pkg::rsp_type want;
      if (reset) begin
         oc_lim        = mfp_pkg::RST_OC_LIMIT;
         ot_lim        = mfp_pkg::RST_OT_LIMIT;
         stall_spd_lim = mfp_pkg::RST_STALL_SPEED;
         stall_cur_lim = mfp_pkg::RST_STALL_CUR;
         stall_ms      = mfp_pkg::RST_STALL_TIME;
         cool_ms       = mfp_pkg::RST_COOL_TIME;
         mode_q        = mfp_pkg::MODE_IDLE;
         flags_q       = '0;
         stall_tmr     = '0;
         cool_tmr      = '0;
         fault_cnt     = '0;
         rsp_due.delete();
      end else begin
         if (csr_we) begin
            case (csr_index)
               mfp_pkg::CSR_OC_LIMIT:    oc_lim        = csr_wdata[14:0];
               mfp_pkg::CSR_OT_LIMIT:    ot_lim        = csr_wdata;
               mfp_pkg::CSR_STALL_SPEED: stall_spd_lim = csr_wdata[14:0];
               mfp_pkg::CSR_STALL_CUR:   stall_cur_lim = csr_wdata[14:0];
               mfp_pkg::CSR_STALL_TIME:  stall_ms      = csr_wdata;
               mfp_pkg::CSR_COOL_TIME:   cool_ms       = csr_wdata;
               default: ;
            endcase
         end
         if (rsp.valid && rsp.ready) begin
            got.mode         = rsp.mode;
            got.fault_bits   = rsp.fault_bits;
            got.faults_seen  = rsp.faults_seen;
            got.drive_enable = rsp.drive_enable;
            seen_cnt++;
            if (rsp_due.size() == 0) begin
               $display("%0t checker: response beat with none expected, got %p", $time, got);
               err_cnt++;
            end else begin
               want = rsp_due.pop_front();
               if (got.mode !== want.mode)
                  field_err("mode", 16'(want.mode), 16'(got.mode));
               if (got.fault_bits !== want.fault_bits)
                  field_err("fault_bits", 16'(want.fault_bits), 16'(got.fault_bits));
               if (got.faults_seen !== want.faults_seen)
                  field_err("faults_seen", want.faults_seen, got.faults_seen);
               if (got.drive_enable !== want.drive_enable)
                  field_err("drive_enable", 16'(want.drive_enable), 16'(got.drive_enable));
            end
         end
         if (req.valid && req.ready)
            rsp_due.push_back(protect_step(req.opcode, req.current_ma, req.temp_decic,
                                           req.motor_speed));
      end
      mismatches  <= err_cnt;
      outstanding <= rsp_due.size();
      checked     <= seen_cnt;
   end

endmodule

// ===== dv/motor_fault_protection_top_tb.sv =====
// Testbench top for the motor fault protection block: stimulus, limit settings and verdict.
module motor_fault_protection_top_tb;

   localparam int LIMIT        = 200000;
   localparam int PHASE_BEATS  = 144;
   localparam logic [mfp_pkg::CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [mfp_pkg::CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                           clock;
   logic                           reset;
   logic                           csr_we;
   logic [mfp_pkg::CSR_IDX_W-1:0]  csr_index;
   logic [mfp_pkg::CSR_DATA_W-1:0] csr_wdata;

   int mismatches;
   int outstanding;
   int checked;
   int cycles = 0;
   int gap_pct = 8;
   int beats = 0;
   int settings = 0;

   // current limits, used only to aim the stimulus
   logic [14:0]        oc_now   = mfp_pkg::RST_OC_LIMIT;
   logic signed [15:0] ot_now   = mfp_pkg::RST_OT_LIMIT;
   logic [14:0]        spd_now  = mfp_pkg::RST_STALL_SPEED;
   logic [14:0]        scur_now = mfp_pkg::RST_STALL_CUR;

   mfp_req_if req_ch ();
   mfp_rsp_if rsp_ch ();

   motor_fault_protection_top dut (
      .clock     (clock),
      .reset     (reset),
      .req       (req_ch),
      .rsp       (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   mfp_checker #(.TICK_MS(10)) chk (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles == LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   always @(posedge clock) begin
      rsp_ch.ready <= ($urandom_range(99) >= gap_pct);
   end

   function automatic mfp_pkg::req_type mk(input logic op, input int cur, temp, spd);
      mfp_pkg::req_type b;
      b.opcode      = op;
      b.current_ma  = 16'(cur);
      b.temp_decic  = 16'(temp);
      b.motor_speed = 16'(spd);
      return b;
   endfunction

   function automatic int flip(input int v);
      return $urandom_range(1) ? -v : v;
   endfunction

   // kind below 55: stall run; below 92: noise; else clear command
   function automatic mfp_pkg::req_type pick_beat(input int kind);
      mfp_pkg::req_type b;
      int               lo;
      int               hi;
      if (kind < 55) begin
         lo = int'(scur_now) + 1;
         hi = (int'(oc_now) > lo) ? int'(oc_now) : lo;
         b = mk(($urandom_range(99) < 3) ? mfp_pkg::OP_CLEAR : mfp_pkg::OP_UPDATE,
                flip($urandom_range(hi, lo)),
                int'(ot_now) - int'($urandom_range(300, 1)),
                flip($urandom_range(int'(spd_now), 0)));
      end else if (kind < 92) begin
         b.opcode = ($urandom_range(99) < 5) ? mfp_pkg::OP_CLEAR : mfp_pkg::OP_UPDATE;
         case ($urandom_range(3))
            0, 1:    b.current_ma = 16'($urandom);
            2:       b.current_ma = 16'(flip(int'(oc_now) + int'($urandom_range(4)) - 2));
            default: b.current_ma = 16'(flip($urandom_range(int'(scur_now) + 2, 0)));
         endcase
         if ($urandom_range(1))
            b.temp_decic = 16'($urandom);
         else
            b.temp_decic = 16'(int'(ot_now) + int'($urandom_range(4)) - 2);
         if ($urandom_range(1))
            b.motor_speed = 16'($urandom);
         else
            b.motor_speed = 16'(flip($urandom_range(int'(spd_now) + 1, 0)));
      end else begin
         b = mk(mfp_pkg::OP_CLEAR, $urandom, $urandom, $urandom);
      end
      return b;
   endfunction

   task automatic send_beat(input mfp_pkg::req_type b);
      while ($urandom_range(99) < gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid       <= 1'b1;
      req_ch.opcode      <= b.opcode;
      req_ch.current_ma  <= b.current_ma;
      req_ch.temp_decic  <= b.temp_decic;
      req_ch.motor_speed <= b.motor_speed;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      beats++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic put_reg(input logic [mfp_pkg::CSR_IDX_W-1:0] idx, input logic [15:0] data);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
   endtask

   task automatic write_cfg(input logic [14:0] oc, input logic signed [15:0] ot,
                            input logic [14:0] spd, input logic [14:0] scur,
                            input logic [15:0] st, input logic [15:0] cool);
      put_reg(mfp_pkg::CSR_OC_LIMIT, 16'(oc));
      put_reg(mfp_pkg::CSR_OT_LIMIT, ot);
      put_reg(mfp_pkg::CSR_STALL_SPEED, 16'(spd));
      put_reg(mfp_pkg::CSR_STALL_CUR, 16'(scur));
      put_reg(mfp_pkg::CSR_STALL_TIME, st);
      put_reg(mfp_pkg::CSR_COOL_TIME, cool);
      csr_we   <= 1'b0;
      @(posedge clock);
      oc_now   = oc;
      ot_now   = ot;
      spd_now  = spd;
      scur_now = scur;
      settings++;
   endtask

   initial begin
      int              sent;
      int              kind;
      int              len;
      logic [14:0]     oc;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_index          <= '0;
      csr_wdata          <= '0;
      req_ch.valid       <= 1'b0;
      req_ch.opcode      <= mfp_pkg::OP_UPDATE;
      req_ch.current_ma  <= '0;
      req_ch.temp_decic  <= '0;
      req_ch.motor_speed <= '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // default limits: overcurrent and overtemperature faults, clear with junk payload, stall build-up and reset
      send_beat(mk(mfp_pkg::OP_CLEAR, 0, 0, 0));
      send_beat(mk(mfp_pkg::OP_UPDATE, 100, 200, 1000));
      send_beat(mk(mfp_pkg::OP_UPDATE, 0, 0, 0));
      send_beat(mk(mfp_pkg::OP_UPDATE, 32767, 0, 1000));
      send_beat(mk(mfp_pkg::OP_UPDATE, 0, 0, 0));
      send_beat(mk(mfp_pkg::OP_CLEAR, 32767, 32767, 32767));
      send_beat(mk(mfp_pkg::OP_UPDATE, 5000, 801, 1000));
      send_beat(mk(mfp_pkg::OP_CLEAR, -32768, -32768, -32768));
      send_beat(mk(mfp_pkg::OP_UPDATE, -32768, 0, 0));
      send_beat(mk(mfp_pkg::OP_CLEAR, 0, 0, 0));
      send_beat(mk(mfp_pkg::OP_UPDATE, 3001, -32768, 49));
      send_beat(mk(mfp_pkg::OP_UPDATE, -3001, 800, -49));
      send_beat(mk(mfp_pkg::OP_UPDATE, 3001, 0, -32768));
      send_beat(mk(mfp_pkg::OP_UPDATE, 3000, 0, 0));
      settle();

      // stall timer survives a cooldown and then completes
      write_cfg(15'd20000, 16'sd800, 15'd50, 15'd3000, 16'd30, 16'd10);
      send_beat(mk(mfp_pkg::OP_UPDATE, 4000, 0, 0));
      send_beat(mk(mfp_pkg::OP_UPDATE, 25000, 0, 0));
      send_beat(mk(mfp_pkg::OP_UPDATE, 0, 0, 0));
      send_beat(mk(mfp_pkg::OP_UPDATE, 4000, 0, 0));
      send_beat(mk(mfp_pkg::OP_UPDATE, 4000, 0, 0));
      send_beat(mk(mfp_pkg::OP_UPDATE, 0, 0, 0));
      settle();

      // zero stall and cooldown time, widest limits
      write_cfg(15'h7FFF, 16'sh7FFF, 15'h7FFF, 15'd0, 16'd0, 16'd0);
      send_beat(mk(mfp_pkg::OP_UPDATE, 1, -32768, 0));
      send_beat(mk(mfp_pkg::OP_UPDATE, 0, 0, 0));
      send_beat(mk(mfp_pkg::OP_UPDATE, -32768, 32767, 32767));
      settle();

      // writes to unused indexes must not disturb anything; then the lowest limits
      put_reg(CSR_SPARE_LO, 16'hFFFF);
      put_reg(CSR_SPARE_HI, 16'h0000);
      write_cfg(15'd0, -16'sd32768, 15'd0, 15'd0, 16'd0, 16'd0);
      send_beat(mk(mfp_pkg::OP_UPDATE, 0, -32767, 0));
      send_beat(mk(mfp_pkg::OP_UPDATE, 0, -32768, 0));

      for (int p = 0; p < 8; p++) begin
         settle();
         case (p)
            0: write_cfg(mfp_pkg::RST_OC_LIMIT, mfp_pkg::RST_OT_LIMIT,
                         mfp_pkg::RST_STALL_SPEED, mfp_pkg::RST_STALL_CUR,
                         mfp_pkg::RST_STALL_TIME, mfp_pkg::RST_COOL_TIME);
            1: write_cfg(15'h7FFF, 16'sh7FFF, 15'h7FFF, 15'h7FFF, 16'hFFFF, 16'hFFFF);
            default: begin
               oc = 15'($urandom_range(20000, 500));
               write_cfg(oc, 16'($urandom_range(1200, 0)) - 16'sd200,
                         15'($urandom_range(200, 0)), 15'($urandom_range(int'(oc), 0)),
                         16'($urandom_range(120, 0)), 16'($urandom_range(150, 0)));
            end
         endcase
         gap_pct = (p == 3) ? 0 : 8;
         sent = 0;
         while (sent < PHASE_BEATS) begin
            kind = $urandom_range(99);
            len  = (kind < 92) ? $urandom_range(12, 1) : 1;
            for (int k = 0; k < len && sent < PHASE_BEATS; k++) begin
               send_beat(pick_beat(kind));
               sent++;
            end
         end
      end
      settle();

      $display("run: %0d request beats sent, %0d response beats checked", beats, checked);
      $display("run: %0d limit settings, idle stretches on both channels", settings);
      if (mismatches == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
